// ----- design/mcc_pkg.sv -----
// Shared constants and pipeline control type for the MCC block.
`timescale 1ns / 1ps
package mcc_pkg;

  localparam int COUNT_BITS_DEF = 16;
  localparam int FRAC_BITS_DEF  = 15;

  typedef struct packed {
    logic vld;
    logic neg;
    logic mzero;
    logic pos_empty;
    logic neg_empty;
  } mcc_ctl_t;

  localparam int CTL_W = $bits(mcc_ctl_t);

endpackage

// ----- design/mcc_qdiv.sv -----
// Pipelined restoring divider, one quotient bit per stage: floor(num * 2^QB / den), num <= den.
`timescale 1ns / 1ps
module mcc_qdiv #(
  parameter int DW = 17,
  parameter int QB = 15,
  parameter int SW = 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic [DW-1:0] num,
  input  logic [DW-1:0] den,
  input  logic [SW-1:0] side_in,
  output logic [QB:0]   q,
  output logic [SW-1:0] side_out
);

  logic [DW-1:0] rem_r  [QB+1];
  logic [DW-1:0] den_r  [QB+1];
  logic [QB:0]   q_r    [QB+1];
  logic [SW-1:0] side_r [QB+1];

  for (genvar s = 0; s <= QB; s++) begin : g_stg
    logic [DW:0]   t;
    logic [DW-1:0] d;
    logic [QB:0]   qi;
    logic [SW-1:0] si;
    logic          hit;

    if (s == 0) begin : g_first
      assign t  = {1'b0, num};
      assign d  = den;
      assign qi = '0;
      assign si = side_in;
    end else begin : g_next
      assign t  = {rem_r[s-1], 1'b0};
      assign d  = den_r[s-1];
      assign qi = q_r[s-1];
      assign si = side_r[s-1];
    end

    assign hit = (t >= {1'b0, d});

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        side_r[s] <= '0;
      end else if (en) begin
        side_r[s] <= si;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[s] <= hit ? DW'(t - {1'b0, d}) : t[DW-1:0];
        den_r[s] <= d;
        q_r[s]   <= qi | ({{QB{1'b0}}, hit} << (QB - s));
      end
    end
  end

  assign q        = q_r[QB];
  assign side_out = side_r[QB];

endmodule

// ----- design/mcc_isqrt.sv -----
// Pipelined restoring integer square root, one root bit per stage.
`timescale 1ns / 1ps
module mcc_isqrt #(
  parameter int F  = 15,
  parameter int SW = 5
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic [2*F:0]  rad,
  input  logic [SW-1:0] side_in,
  output logic [F:0]    root,
  output logic [SW-1:0] side_out
);

  localparam int NS = F + 1;
  localparam int RW = F + 4;

  logic [2*NS-1:0] rad_r  [NS];
  logic [RW-1:0]   rem_r  [NS];
  logic [F:0]      root_r [NS];
  logic [SW-1:0]   side_r [NS];

  for (genvar s = 0; s < NS; s++) begin : g_stg
    logic [2*NS-1:0] ri;
    logic [RW-1:0]   rp;
    logic [F:0]      qp;
    logic [SW-1:0]   si;
    logic [RW-1:0]   t;
    logic [RW-1:0]   trial;
    logic            hit;

    if (s == 0) begin : g_first
      assign ri = {1'b0, rad};
      assign rp = '0;
      assign qp = '0;
      assign si = side_in;
    end else begin : g_next
      assign ri = rad_r[s-1];
      assign rp = rem_r[s-1];
      assign qp = root_r[s-1];
      assign si = side_r[s-1];
    end

    assign t     = {rp[RW-3:0], ri[2*(NS-1-s)+1 -: 2]};
    assign trial = {1'b0, qp, 2'b01};
    assign hit   = (t >= trial);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        side_r[s] <= '0;
      end else if (en) begin
        side_r[s] <= si;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rad_r[s]  <= ri;
        rem_r[s]  <= hit ? RW'(t - trial) : t;
        root_r[s] <= {qp[F-1:0], hit};
      end
    end
  end

  assign root     = root_r[NS-1];
  assign side_out = side_r[NS-1];

endmodule

// ----- design/mcc_front.sv -----
// Front pipeline: marginal sums, numerator squared and product of the sums.
`timescale 1ns / 1ps
module mcc_front #(
  parameter int C = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  en,
  input  logic                  in_vld,
  input  logic [3:0][C-1:0]     cnt_in,
  output logic [4*C-1:0]        nsq,
  output logic [4*C+3:0]        prod,
  output mcc_pkg::mcc_ctl_t     ctl,
  output logic [3:0][C-1:0]     cnt_out
);
  import mcc_pkg::*;

  localparam int SW = C + 1;

  logic [C-1:0]  tp, fp, tn, fn;
  logic [SW-1:0] spp, spos, sneg, snn;
  mcc_ctl_t      ctl1_nxt;
  mcc_ctl_t      ctl2_nxt;

  mcc_ctl_t         ctl1_r, ctl2_r, ctl3_r, ctl4_r;
  logic [3:0][C-1:0] cnt1_r, cnt2_r, cnt3_r, cnt4_r;
  logic [SW-1:0]    spp1_r, spos1_r, sneg1_r, snn1_r;
  logic [2*C-1:0]   pa1_r, pb1_r;
  logic [2*C-1:0]   mag2_r;
  logic [2*SW-1:0]  ab2_r;
  logic [SW-1:0]    sneg2_r, snn2_r, snn3_r;
  logic [2*C-1:0]   hh3_r, hl3_r, ll3_r;
  logic [3*SW-1:0]  abc3_r;
  logic [4*C-1:0]   nsq4_r;
  logic [4*SW-1:0]  p4_r;
  logic             neg2;

  assign tp = cnt_in[0];
  assign fp = cnt_in[1];
  assign tn = cnt_in[2];
  assign fn = cnt_in[3];

  assign spp  = {1'b0, tp} + {1'b0, fp};
  assign spos = {1'b0, tp} + {1'b0, fn};
  assign sneg = {1'b0, tn} + {1'b0, fp};
  assign snn  = {1'b0, tn} + {1'b0, fn};

  always_comb begin
    ctl1_nxt           = '0;
    ctl1_nxt.vld       = in_vld;
    ctl1_nxt.mzero     = (spp == '0) || (spos == '0) || (sneg == '0) || (snn == '0);
    ctl1_nxt.pos_empty = (spos == '0);
    ctl1_nxt.neg_empty = (sneg == '0);
  end

  assign neg2 = (pb1_r > pa1_r);

  always_comb begin
    ctl2_nxt     = ctl1_r;
    ctl2_nxt.neg = neg2;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl1_r <= '0;
      ctl2_r <= '0;
      ctl3_r <= '0;
      ctl4_r <= '0;
    end else if (en) begin
      ctl1_r <= ctl1_nxt;
      ctl2_r <= ctl2_nxt;
      ctl3_r <= ctl2_r;
      ctl4_r <= ctl3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cnt1_r  <= cnt_in;
      spp1_r  <= spp;
      spos1_r <= spos;
      sneg1_r <= sneg;
      snn1_r  <= snn;
      pa1_r   <= (2*C)'(tp) * (2*C)'(tn);
      pb1_r   <= (2*C)'(fp) * (2*C)'(fn);

      cnt2_r  <= cnt1_r;
      mag2_r  <= neg2 ? pb1_r - pa1_r : pa1_r - pb1_r;
      ab2_r   <= (2*SW)'(spp1_r) * (2*SW)'(spos1_r);
      sneg2_r <= sneg1_r;
      snn2_r  <= snn1_r;

      cnt3_r  <= cnt2_r;
      hh3_r   <= (2*C)'(mag2_r[2*C-1:C]) * (2*C)'(mag2_r[2*C-1:C]);
      hl3_r   <= (2*C)'(mag2_r[2*C-1:C]) * (2*C)'(mag2_r[C-1:0]);
      ll3_r   <= (2*C)'(mag2_r[C-1:0]) * (2*C)'(mag2_r[C-1:0]);
      abc3_r  <= (3*SW)'(ab2_r) * (3*SW)'(sneg2_r);
      snn3_r  <= snn2_r;

      cnt4_r  <= cnt3_r;
      nsq4_r  <= ((4*C)'(hh3_r) << (2*C)) + ((4*C)'(hl3_r) << (C+1)) + (4*C)'(ll3_r);
      p4_r    <= (4*SW)'(abc3_r) * (4*SW)'(snn3_r);
    end
  end

  assign nsq     = nsq4_r;
  assign prod    = p4_r;
  assign ctl     = ctl4_r;
  assign cnt_out = cnt4_r;

endmodule

// ----- design/mcc_from_confusion_counts_top.sv -----
// Top level: Matthews correlation coefficient and class rates from confusion counts.
//
//   channel | direction | handshake         | beat
//   in_     | input     | in_valid/in_stall | true_pos, false_pos, true_neg, false_neg
//   out_    | output    | out_valid/out_stall | mcc, four rates, three flags
//
// One beat per cycle in and out while no valid output beat is stalled. Each beat
// passes the front pipeline, long divider, square root and output register in turn.
// The rates run beside the square root over FRAC_BITS+1 divider stages.
// Reset clears valid bits and side registers; other payload registers are not reset.
// A stalled output beat freezes the whole pipeline and raises in_stall.
`timescale 1ns / 1ps
module mcc_from_confusion_counts_top #(
  parameter int COUNT_BITS = mcc_pkg::COUNT_BITS_DEF,
  parameter int FRAC_BITS  = mcc_pkg::FRAC_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [COUNT_BITS-1:0]       in_true_pos,
  input  logic [COUNT_BITS-1:0]       in_false_pos,
  input  logic [COUNT_BITS-1:0]       in_true_neg,
  input  logic [COUNT_BITS-1:0]       in_false_neg,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic signed [FRAC_BITS+1:0] out_mcc,
  output logic [FRAC_BITS:0]          out_tp_rate,
  output logic [FRAC_BITS:0]          out_fp_rate,
  output logic [FRAC_BITS:0]          out_tn_rate,
  output logic [FRAC_BITS:0]          out_fn_rate,
  output logic                        out_pos_class_empty,
  output logic                        out_neg_class_empty,
  output logic                        out_margin_zero
);
  import mcc_pkg::*;

  localparam int C  = COUNT_BITS;
  localparam int F  = FRAC_BITS;
  localparam int SW = C + 1;
  localparam int BW = 4 * SW;

  localparam logic signed [F+1:0] MCC_ONE     = (F+2)'(1 << F);
  localparam logic signed [F+1:0] MCC_NEG_ONE = -MCC_ONE;
  localparam logic [F+1:0]        RATE_FULL   = (F+2)'(1 << F);
  localparam logic [F+1:0]        RATE_LOW    = (F+2)'((1 << F) - 1);

  logic              en;
  logic [3:0][C-1:0] cnt_in, cnt_f, cnt_d;
  logic [4*C-1:0]    nsq_f;
  logic [BW-1:0]     prod_f;
  mcc_ctl_t          ctl_f, ctl_d, ctl_s;
  logic [2*F:0]      q_big;
  logic [F:0]        root;
  logic [SW-1:0]     s_pos, s_neg;
  logic [F:0]        tpr, fpr, tnr, fnr;
  logic              tp_e, fp_e, tn_e, fn_e;
  logic [F+1:0]      mcc_nxt;

  logic              out_vld_r;
  logic [F+1:0]      mcc_r;
  logic [F:0]        tpr_r, fpr_r, tnr_r, fnr_r;
  logic              pos_e_r, neg_e_r, mzero_r;
  logic [F+1:0]      pos_rate_sum;

  assign en       = !out_vld_r || !out_stall;
  assign in_stall = !en;

  assign cnt_in[0] = in_true_pos;
  assign cnt_in[1] = in_false_pos;
  assign cnt_in[2] = in_true_neg;
  assign cnt_in[3] = in_false_neg;

  mcc_front #(.C(C)) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_vld  (in_valid),
    .cnt_in  (cnt_in),
    .nsq     (nsq_f),
    .prod    (prod_f),
    .ctl     (ctl_f),
    .cnt_out (cnt_f)
  );

  mcc_qdiv #(.DW(BW), .QB(2*F), .SW(CTL_W + 4*C)) u_qdiv_big (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .num      (BW'(nsq_f)),
    .den      (prod_f),
    .side_in  ({ctl_f, cnt_f}),
    .q        (q_big),
    .side_out ({ctl_d, cnt_d})
  );

  assign s_pos = {1'b0, cnt_d[0]} + {1'b0, cnt_d[3]};
  assign s_neg = {1'b0, cnt_d[2]} + {1'b0, cnt_d[1]};

  mcc_isqrt #(.F(F), .SW(CTL_W)) u_isqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .rad      (q_big),
    .side_in  (ctl_d),
    .root     (root),
    .side_out (ctl_s)
  );

  mcc_qdiv #(.DW(SW), .QB(F), .SW(1)) u_qdiv_tp (
    .clk (clk), .rst_n (rst_n), .en (en),
    .num ({1'b0, cnt_d[0]}), .den (s_pos), .side_in (ctl_d.pos_empty),
    .q (tpr), .side_out (tp_e)
  );

  mcc_qdiv #(.DW(SW), .QB(F), .SW(1)) u_qdiv_fp (
    .clk (clk), .rst_n (rst_n), .en (en),
    .num ({1'b0, cnt_d[1]}), .den (s_neg), .side_in (ctl_d.neg_empty),
    .q (fpr), .side_out (fp_e)
  );

  mcc_qdiv #(.DW(SW), .QB(F), .SW(1)) u_qdiv_tn (
    .clk (clk), .rst_n (rst_n), .en (en),
    .num ({1'b0, cnt_d[2]}), .den (s_neg), .side_in (ctl_d.neg_empty),
    .q (tnr), .side_out (tn_e)
  );

  mcc_qdiv #(.DW(SW), .QB(F), .SW(1)) u_qdiv_fn (
    .clk (clk), .rst_n (rst_n), .en (en),
    .num ({1'b0, cnt_d[3]}), .den (s_pos), .side_in (ctl_d.pos_empty),
    .q (fnr), .side_out (fn_e)
  );

  always_comb begin
    if (ctl_s.mzero) begin
      mcc_nxt = '0;
    end else if (ctl_s.neg) begin
      mcc_nxt = (F+2)'(0) - {1'b0, root};
    end else begin
      mcc_nxt = {1'b0, root};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (en) begin
      out_vld_r <= ctl_s.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mcc_r   <= mcc_nxt;
      tpr_r   <= tp_e ? '0 : tpr;
      fpr_r   <= fp_e ? '0 : fpr;
      tnr_r   <= tn_e ? '0 : tnr;
      fnr_r   <= fn_e ? '0 : fnr;
      pos_e_r <= ctl_s.pos_empty;
      neg_e_r <= ctl_s.neg_empty;
      mzero_r <= ctl_s.mzero;
    end
  end

  assign out_valid           = out_vld_r;
  assign out_mcc             = $signed(mcc_r);
  assign out_tp_rate         = tpr_r;
  assign out_fp_rate         = fpr_r;
  assign out_tn_rate         = tnr_r;
  assign out_fn_rate         = fnr_r;
  assign out_pos_class_empty = pos_e_r;
  assign out_neg_class_empty = neg_e_r;
  assign out_margin_zero     = mzero_r;

  assign pos_rate_sum = {1'b0, tpr_r} + {1'b0, fnr_r};

  a_mzero_clears_mcc: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_margin_zero |-> out_mcc == '0)
    else $error("mcc not zero with a zero margin");

  a_pos_empty_rates: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_pos_class_empty |-> out_tp_rate == '0 && out_fn_rate == '0)
    else $error("positive rates not zero for an empty class");

  a_pos_rates_sum: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_pos_class_empty |->
      pos_rate_sum == RATE_FULL || pos_rate_sum == RATE_LOW)
    else $error("tp_rate and fn_rate do not add to one");

  a_mcc_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_mcc <= MCC_ONE && out_mcc >= MCC_NEG_ONE)
    else $error("mcc outside plus or minus one");

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input held off with room in the output register");

endmodule
